@@ hdl/rfc_pkg.sv @@
// shared types, constants and status decoding for the reply frame checker
package rfc_pkg;

   localparam logic [7:0] START_MARK = 8'hF5;

   // command codes
   localparam logic [7:0] CMD_VERIFY      = 8'h01;
   localparam logic [7:0] CMD_ENROLL_2    = 8'h02;
   localparam logic [7:0] CMD_ENROLL_3    = 8'h03;
   localparam logic [7:0] CMD_DELETE_ONE  = 8'h04;
   localparam logic [7:0] CMD_DELETE_ALL  = 8'h05;
   localparam logic [7:0] CMD_USER_COUNT  = 8'h09;
   localparam logic [7:0] CMD_COMPARE_ONE = 8'h0B;
   localparam logic [7:0] CMD_IDENTIFY    = 8'h0C;

   // status codes
   localparam logic [7:0] ACK_OK         = 8'h00;
   localparam logic [7:0] ACK_LEVEL_1    = 8'h01;
   localparam logic [7:0] ACK_LEVEL_2    = 8'h02;
   localparam logic [7:0] ACK_LEVEL_3    = 8'h03;

   // byte positions inside a frame
   localparam logic [2:0] POS_START  = 3'd0;
   localparam logic [2:0] POS_ECHO   = 3'd1;
   localparam logic [2:0] POS_ARG_HI = 3'd2;
   localparam logic [2:0] POS_ID     = 3'd3;
   localparam logic [2:0] POS_STATUS = 3'd4;
   localparam logic [2:0] POS_ARG_LO = 3'd5;
   localparam logic [2:0] POS_CHECK  = 3'd6;
   localparam logic [2:0] POS_END    = 3'd7;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_BAD_START  = 2'd1,
      ERR_CMD_ECHO   = 2'd2,
      ERR_CHECKSUM   = 2'd3
   } err_kind_type;

   typedef struct packed {
      logic       start_good;
      logic       echo_good;
      logic       sum_good;
      logic [7:0] id_byte;
      logic [7:0] status_byte;
   } frame_status_type;

   typedef struct packed {
      logic accept;
      logic load;
   } decode_type;

   function automatic decode_type decode_status(input logic [7:0] cmd,
                                                input logic [7:0] st);
      decode_type d;
      d.accept = 1'b0;
      d.load   = 1'b0;
      case (cmd)
         CMD_VERIFY, CMD_ENROLL_2, CMD_ENROLL_3, CMD_DELETE_ONE,
         CMD_DELETE_ALL, CMD_COMPARE_ONE: begin
            d.accept = (st == ACK_OK);
         end
         CMD_USER_COUNT: begin
            d.load   = (st == ACK_OK);
            d.accept = d.load;
         end
         CMD_IDENTIFY: begin
            d.load   = (st == ACK_LEVEL_1) || (st == ACK_LEVEL_2) || (st == ACK_LEVEL_3);
            d.accept = d.load;
         end
         default: begin
            d.accept = 1'b0;
            d.load   = 1'b0;
         end
      endcase
      return d;
   endfunction

endpackage

@@ hdl/rfc_if.sv @@
// request and response channel interfaces of the reply frame checker
interface rfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       frame_valid;
   logic [1:0] error_kind;
   logic [7:0] ack_code;
   logic [7:0] matched_id;
   logic       id_updated;

   modport source (output valid, output accepted, output frame_valid, output error_kind,
                   output ack_code, output matched_id, output id_updated, input ready);
   modport sink   (input valid, input accepted, input frame_valid, input error_kind,
                   input ack_code, input matched_id, input id_updated, output ready);
endinterface

@@ hdl/rfc_frame_track.sv @@
// byte position counter, running xor and per-frame check flags
module rfc_frame_track
   import rfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       rx_byte,
   input  logic [7:0]       expected_cmd,
   output logic             last_byte,
   output frame_status_type status
);

   logic [2:0]       byte_pos_ff, byte_pos_in;
   logic [7:0]       xor_ff, xor_in;
   frame_status_type stat_ff, stat_in;

   always_comb begin
      xor_in  = xor_ff;
      stat_in = stat_ff;
      case (byte_pos_ff)
         POS_START: begin
            stat_in.start_good = (rx_byte == START_MARK);
            xor_in             = '0;
         end
         POS_ECHO: begin
            stat_in.echo_good = (rx_byte == expected_cmd);
            xor_in            = rx_byte;
         end
         POS_ARG_HI, POS_ARG_LO: begin
            xor_in = xor_ff ^ rx_byte;
         end
         POS_ID: begin
            stat_in.id_byte = rx_byte;
            xor_in          = xor_ff ^ rx_byte;
         end
         POS_STATUS: begin
            stat_in.status_byte = rx_byte;
            xor_in              = xor_ff ^ rx_byte;
         end
         POS_CHECK: begin
            stat_in.sum_good = (rx_byte == xor_ff);
         end
         default: begin
            // end marker is not checked
            xor_in = xor_ff;
         end
      endcase
      byte_pos_in = byte_pos_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         xor_ff      <= '0;
         stat_ff     <= '0;
      end else if (take) begin
         byte_pos_ff <= byte_pos_in;
         xor_ff      <= xor_in;
         stat_ff     <= stat_in;
      end
   end

   assign last_byte = (byte_pos_ff == POS_END);
   assign status    = stat_ff;

   a_wrap_to_start: assert property (@(posedge clock) disable iff (reset)
      take && last_byte |=> byte_pos_ff == POS_START)
      else $error("frame counter did not wrap after end byte");

endmodule

@@ hdl/rfc_result.sv @@
// status decoding, stored user id and the response output register
module rfc_result
   import rfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic [7:0]       expected_cmd,
   input  frame_status_type status,
   output logic             out_free,
   rfc_rsp_if.source        rsp
);

   logic         valid_ff, valid_in;
   logic         accepted_ff, accepted_in;
   logic         frame_valid_ff, frame_valid_in;
   err_kind_type error_kind_ff, error_kind_in;
   logic [7:0]   ack_code_ff;
   logic [7:0]   stored_id_ff, stored_id_in;
   logic         id_updated_ff, id_updated_in;
   decode_type   dec;

   always_comb begin
      frame_valid_in = status.start_good && status.echo_good && status.sum_good;
      if (!status.start_good) begin
         error_kind_in = ERR_BAD_START;
      end else if (!status.echo_good) begin
         error_kind_in = ERR_CMD_ECHO;
      end else if (!status.sum_good) begin
         error_kind_in = ERR_CHECKSUM;
      end else begin
         error_kind_in = ERR_NONE;
      end
      dec            = decode_status(expected_cmd, status.status_byte);
      accepted_in    = frame_valid_in && dec.accept;
      id_updated_in  = frame_valid_in && dec.load;
      stored_id_in   = id_updated_in ? status.id_byte : stored_id_ff;
   end

   assign out_free = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         stored_id_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            stored_id_ff <= stored_id_in;
         end
      end
   end

   // payload only moves when a finished frame is loaded
   always_ff @(posedge clock) begin
      if (load) begin
         accepted_ff    <= accepted_in;
         frame_valid_ff <= frame_valid_in;
         error_kind_ff  <= error_kind_in;
         ack_code_ff    <= status.status_byte;
         id_updated_ff  <= id_updated_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.accepted    = accepted_ff;
   assign rsp.frame_valid = frame_valid_ff;
   assign rsp.error_kind  = error_kind_ff;
   assign rsp.ack_code    = ack_code_ff;
   assign rsp.matched_id  = stored_id_ff;
   assign rsp.id_updated  = id_updated_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("pending response overwritten");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("finished frame produced no response");

   a_accept_needs_valid: assert property (@(posedge clock) disable iff (reset)
      valid_ff && accepted_ff |-> frame_valid_ff && error_kind_ff == ERR_NONE)
      else $error("accepted response without a valid frame");

   a_update_needs_accept: assert property (@(posedge clock) disable iff (reset)
      valid_ff && id_updated_ff |-> accepted_ff)
      else $error("id update without acceptance");

endmodule

@@ hdl/reply_frame_checker.sv @@
// top level of the reply frame checker
//
// Receives a reply frame of eight bytes, one request per byte, on the req
// channel and returns one response on the rsp channel for every eighth byte.
// Byte 0 must be the start mark, byte 1 must echo csr_write_data as last
// written, and the xor of bytes 1 to 5 must equal byte 6; byte 7 closes the
// frame. The response carries the check outcome, the raw status byte, the
// per-command accept flag and the stored user id, which a good user-count or
// search reply reloads from byte 3.
// Throughput: one byte per clock cycle unless byte 7 is held for rsp_ready.
// Latency: the response is valid the cycle after byte 7 is taken.
// The response sits in an output register; while it waits, bytes 0 to 6 of
// the next frame are still taken, and only its byte 7 waits for rsp_ready.
// Reset clears the byte counter, check flags, expected command and stored id;
// no response is pending afterwards. There is no resynchronization: every
// eighth byte after reset ends a frame.
// The command register is written with csr_write_en; write it only while idle.
module reply_frame_checker
   import rfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rfc_req_if.sink    req,
   rfc_rsp_if.source  rsp,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   logic [7:0]       expected_cmd_ff;
   logic             last_byte;
   logic             out_free;
   logic             take;
   frame_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_cmd_ff <= '0;
      end else if (csr_write_en) begin
         expected_cmd_ff <= csr_write_data;
      end
   end

   assign req.ready = !last_byte || out_free;
   assign take      = req.valid && req.ready;

   rfc_frame_track u_track (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .rx_byte      (req.rx_byte),
      .expected_cmd (expected_cmd_ff),
      .last_byte    (last_byte),
      .status       (status)
   );

   rfc_result u_result (
      .clock        (clock),
      .reset        (reset),
      .load         (take && last_byte),
      .expected_cmd (expected_cmd_ff),
      .status       (status),
      .out_free     (out_free),
      .rsp          (rsp)
   );

endmodule
